@@ rtl/wheel_command_modbus_framer_top_defines.svh @@
// Assertion macros for the wheel command Modbus framer.
// Used by the top level only; expects signals named clock and reset in scope.
`ifndef WHEEL_COMMAND_MODBUS_FRAMER_TOP_DEFINES_SVH
`define WHEEL_COMMAND_MODBUS_FRAMER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define WCMF_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define WCMF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/wcmf_pkg.sv @@
// Shared types and constants for the wheel command Modbus framer.
// No dependencies.
`timescale 1ns / 1ps

package wcmf_pkg;

   // Command opcodes
   localparam logic [2:0] OP_SINGLE = 3'd0;
   localparam logic [2:0] OP_RAW    = 3'd1;
   localparam logic [2:0] OP_WHEEL  = 3'd2;
   localparam logic [2:0] OP_DIFF   = 3'd3;
   localparam logic [2:0] OP_LINE   = 3'd4;

   // Register indexes
   localparam logic CSR_DEVICE_ADDRESS = 1'b0;
   localparam logic CSR_SPEED_BOUND    = 1'b1;

   localparam logic [7:0]  DEVICE_ADDRESS_RESET = 8'h0A;
   localparam logic [14:0] SPEED_BOUND_RESET    = 15'd20;

   // Frame constants
   localparam logic [7:0]  FUNC_WRITE_SINGLE = 8'h06;
   localparam logic [7:0]  FUNC_WRITE_MULTI  = 8'h10;
   localparam logic [7:0]  REG_QUANTITY      = 8'h04;
   localparam logic [7:0]  BYTE_COUNT        = 8'h08;
   localparam logic [15:0] FLOOR_SPEED       = 16'd4;
   localparam logic [15:0] CRC_INIT          = 16'hFFFF;
   localparam logic [15:0] CRC_POLY          = 16'hA001;

   localparam int IDX_W = 5;
   // Index of the last data byte before the CRC
   localparam logic [IDX_W-1:0] SINGLE_DATA_LAST = 5'd5;
   localparam logic [IDX_W-1:0] MULTI_DATA_LAST  = 5'd14;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MIX_R,
      ST_MIX_L,
      ST_NEG,
      ST_SEND
   } state_type;

   typedef struct packed {
      logic carry_in;
      logic floor_en;
      logic clamp_en;
   } alu_ctrl_type;

endpackage

@@ rtl/wheel_command_modbus_framer_top.sv @@
// Wheel command Modbus framer: turns one motor command into a Modbus RTU frame.
// Usage: the req_ channel takes one command per transfer; the rsp_ channel
// returns the frame one byte per transfer, rsp_frame_end marking the CRC high byte.
// Opcode 0 gives an 8-byte single-register write, opcodes 1 to 4 a 17-byte
// four-register write; opcodes 5 to 7 are taken and produce no bytes.
// Flow: a command is taken only while the sequencer is idle. Opcodes 0 and 1
// go straight to sending, opcode 2 after the negate state, opcodes 3 and 4
// after the right sum, left sum and fourth-wheel negate states, which share
// the add/floor/clamp unit. Bytes then leave at one per cycle through the
// byte-wise CRC while the receiver does not stall.
// Stall: a stalled byte holds in the output register and the sequencer waits;
// the next command may be taken while the final byte still waits.
// Reset (synchronous): clears the sequencer and output valid, and sets
// device_address to 10 and the speed bound to 20. csr_ writes apply at once.
// Depends on wcmf_pkg, wcmf_alu, wcmf_crc and the defines header.
`timescale 1ns / 1ps
`include "wheel_command_modbus_framer_top_defines.svh"

module wheel_command_modbus_framer_top (
   input  logic               clock,
   input  logic               reset,
   // configuration
   input  logic               csr_write_enable,
   input  logic               csr_index,
   input  logic [14:0]        csr_write_data,
   // command channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_opcode,
   input  logic [15:0]        req_reg_address,
   input  logic [15:0]        req_reg_value,
   input  logic signed [15:0] req_speed_0,
   input  logic signed [15:0] req_speed_1,
   input  logic signed [15:0] req_speed_2,
   input  logic signed [15:0] req_speed_3,
   // frame byte channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [7:0]         rsp_frame_byte,
   output logic               rsp_frame_end
);
   import wcmf_pkg::*;

   state_type          state_ff, state_in;
   logic [2:0]         op_ff;
   logic [IDX_W-1:0]   idx_ff;
   logic [15:0]        w_ff [4];
   logic [7:0]         device_address_ff;
   logic [14:0]        speed_bound_ff;
   logic               rsp_valid_ff;
   logic [7:0]         rsp_frame_byte_ff;
   logic               rsp_frame_end_ff;

   logic               req_xfer;
   logic               load_byte;
   logic               is_single;
   logic [IDX_W-1:0]   data_last;
   logic [IDX_W-1:0]   last_idx;
   logic               is_last;
   logic               is_data;
   logic [7:0]         next_byte;
   logic [15:0]        crc_value;
   logic signed [15:0] alu_a, alu_b, alu_result;
   alu_ctrl_type       alu_ctrl;
   logic               steer_pos, steer_neg;

   assign req_xfer  = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         device_address_ff <= DEVICE_ADDRESS_RESET;
         speed_bound_ff    <= SPEED_BOUND_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_DEVICE_ADDRESS: device_address_ff <= csr_write_data[7:0];
            CSR_SPEED_BOUND:    speed_bound_ff    <= csr_write_data;
            default:            ;
         endcase
      end
   end

   // Frame geometry
   assign is_single = (op_ff == OP_SINGLE);
   assign data_last = is_single ? SINGLE_DATA_LAST : MULTI_DATA_LAST;
   assign last_idx  = data_last + 5'd2;
   assign is_last   = (idx_ff == last_idx);
   assign is_data   = (idx_ff <= data_last);

   // Steer sign for the line-drive mix
   assign steer_pos = !w_ff[1][15] && (|w_ff[1]);
   assign steer_neg = w_ff[1][15];

   // Select the next frame byte
   always_comb begin
      next_byte = 8'h00;
      if (!is_data) begin
         next_byte = (idx_ff == data_last + 5'd1) ? crc_value[7:0] : crc_value[15:8];
      end else if (is_single) begin
         case (idx_ff)
            5'd0:    next_byte = device_address_ff;
            5'd1:    next_byte = FUNC_WRITE_SINGLE;
            5'd2:    next_byte = w_ff[0][15:8];
            5'd3:    next_byte = w_ff[0][7:0];
            5'd4:    next_byte = w_ff[1][15:8];
            5'd5:    next_byte = w_ff[1][7:0];
            default: next_byte = 8'h00;
         endcase
      end else begin
         case (idx_ff)
            5'd0:    next_byte = device_address_ff;
            5'd1:    next_byte = FUNC_WRITE_MULTI;
            5'd5:    next_byte = REG_QUANTITY;
            5'd6:    next_byte = BYTE_COUNT;
            5'd7:    next_byte = w_ff[0][15:8];
            5'd8:    next_byte = w_ff[0][7:0];
            5'd9:    next_byte = w_ff[1][15:8];
            5'd10:   next_byte = w_ff[1][7:0];
            5'd11:   next_byte = w_ff[2][15:8];
            5'd12:   next_byte = w_ff[2][7:0];
            5'd13:   next_byte = w_ff[3][15:8];
            5'd14:   next_byte = w_ff[3][7:0];
            default: next_byte = 8'h00;
         endcase
      end
   end

   // Sequencer: next state and shared unit operands
   always_comb begin
      state_in  = state_ff;
      alu_a     = '0;
      alu_b     = '0;
      alu_ctrl  = '0;
      load_byte = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               if (req_opcode inside {OP_SINGLE, OP_RAW}) begin
                  state_in = ST_SEND;
               end else if (req_opcode == OP_WHEEL) begin
                  state_in = ST_NEG;
               end else if (req_opcode inside {OP_DIFF, OP_LINE}) begin
                  state_in = ST_MIX_R;
               end
            end
         end
         ST_MIX_R: begin
            // right = linear - angular, or base minus full / plus half steer
            alu_a             = $signed(w_ff[0]);
            alu_ctrl.clamp_en = 1'b1;
            alu_ctrl.floor_en = (op_ff == OP_LINE);
            if (op_ff == OP_DIFF || steer_pos) begin
               alu_b             = $signed(~w_ff[1]);
               alu_ctrl.carry_in = 1'b1;
            end else if (steer_neg) begin
               alu_b             = $signed({1'b0, ~w_ff[1][15:1]});
               alu_ctrl.carry_in = ~w_ff[1][0];
            end
            state_in = ST_MIX_L;
         end
         ST_MIX_L: begin
            // left = linear + angular, or base plus half / full steer
            alu_a             = $signed(w_ff[0]);
            alu_ctrl.clamp_en = 1'b1;
            alu_ctrl.floor_en = (op_ff == OP_LINE);
            if (op_ff == OP_DIFF || steer_neg) begin
               alu_b = $signed(w_ff[1]);
            end else if (steer_pos) begin
               alu_b = $signed({1'b0, w_ff[1][15:1]});
            end
            state_in = ST_NEG;
         end
         ST_NEG: begin
            // negate the fourth wheel
            alu_b             = $signed(~w_ff[3]);
            alu_ctrl.carry_in = 1'b1;
            state_in          = ST_SEND;
         end
         ST_SEND: begin
            load_byte = !rsp_valid_ff || !rsp_stall;
            if (load_byte && is_last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Hold the command and the mixed wheel speeds
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         op_ff   <= req_opcode;
         w_ff[0] <= (req_opcode == OP_SINGLE) ? req_reg_address : req_speed_0;
         w_ff[1] <= (req_opcode == OP_SINGLE) ? req_reg_value : req_speed_1;
         w_ff[2] <= req_speed_2;
         w_ff[3] <= req_speed_3;
      end else begin
         case (state_ff)
            ST_MIX_R: w_ff[3] <= alu_result;
            ST_MIX_L: begin
               w_ff[0] <= w_ff[3];
               w_ff[1] <= w_ff[3];
               w_ff[2] <= alu_result;
               w_ff[3] <= alu_result;
            end
            ST_NEG:   w_ff[3] <= alu_result;
            default:  ;
         endcase
      end
   end

   // Byte index: restart on a command, advance per loaded byte
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else if (req_xfer) begin
         idx_ff <= '0;
      end else if (load_byte) begin
         idx_ff <= idx_ff + 5'd1;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_byte) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_byte) begin
         rsp_frame_byte_ff <= next_byte;
         rsp_frame_end_ff  <= is_last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_frame_byte = rsp_frame_byte_ff;
   assign rsp_frame_end  = rsp_frame_end_ff;

   wcmf_alu u_alu (
      .alu_a       (alu_a),
      .alu_b       (alu_b),
      .alu_ctrl    (alu_ctrl),
      .speed_bound (speed_bound_ff),
      .alu_result  (alu_result)
   );

   wcmf_crc u_crc (
      .clock      (clock),
      .crc_clear  (req_xfer),
      .crc_update (load_byte && is_data),
      .crc_data   (next_byte),
      .crc_value  (crc_value)
   );

   // Checks
   `WCMF_ASSERT_NEXT(a_idx_restart, req_xfer, idx_ff == '0, "byte index not restarted")
   `WCMF_ASSERT_SAME(a_idx_range, state_ff == ST_SEND, idx_ff <= last_idx, "byte index past frame")
   `WCMF_ASSERT_NEXT(a_end_idle, load_byte && is_last, state_ff == ST_IDLE, "no idle after last")

endmodule

@@ rtl/wcmf_alu.sv @@
// Shared add / floor / clamp unit for the wheel speed mixes.
// Depends on wcmf_pkg.
`timescale 1ns / 1ps

module wcmf_alu (
   input  logic signed [15:0]   alu_a,
   input  logic signed [15:0]   alu_b,
   input  wcmf_pkg::alu_ctrl_type alu_ctrl,
   input  logic [14:0]          speed_bound,
   output logic signed [15:0]   alu_result
);
   import wcmf_pkg::*;

   logic signed [15:0] sum;
   logic signed [15:0] floored;
   logic signed [16:0] pos_lim;
   logic signed [16:0] neg_lim;
   logic signed [16:0] floored_ext;

   // Wrap the sum to 16 bits
   assign sum = alu_a + alu_b + $signed({15'd0, alu_ctrl.carry_in});

   // Raise to the minimum drive speed
   assign floored = (alu_ctrl.floor_en && (sum < $signed(FLOOR_SPEED)))
                    ? $signed(FLOOR_SPEED) : sum;

   assign pos_lim     = $signed({2'b00, speed_bound});
   assign neg_lim     = -pos_lim;
   assign floored_ext = 17'(floored);

   // Clamp to the symmetric limit
   always_comb begin
      alu_result = floored;
      if (alu_ctrl.clamp_en) begin
         if (floored_ext > pos_lim) begin
            alu_result = pos_lim[15:0];
         end else if (floored_ext < neg_lim) begin
            alu_result = neg_lim[15:0];
         end
      end
   end

endmodule

@@ rtl/wcmf_crc.sv @@
// Byte-wise Modbus CRC-16 accumulator (reflected 0xA001, init 0xFFFF).
// Depends on wcmf_pkg.
`timescale 1ns / 1ps

module wcmf_crc (
   input  logic        clock,
   input  logic        crc_clear,
   input  logic        crc_update,
   input  logic [7:0]  crc_data,
   output logic [15:0] crc_value
);
   import wcmf_pkg::*;

   logic [15:0] crc_ff;
   logic [15:0] crc_in;

   // Fold one byte in, one bit per step
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   always_comb begin
      crc_in = crc_ff;
      if (crc_clear) begin
         crc_in = CRC_INIT;
      end else if (crc_update) begin
         crc_in = crc_byte(crc_ff, crc_data);
      end
   end

   always_ff @(posedge clock) begin
      crc_ff <= crc_in;
   end

   assign crc_value = crc_ff;

endmodule

@@ test/tb_wheel_command_modbus_framer_top.sv @@
// Self-checking testbench for wheel_command_modbus_framer_top: directed commands, then
// random ones under several register settings, with both channels idling at random.
// Depends on wcmf_pkg and the framer RTL.
`timescale 1ns / 1ps

module tb_wheel_command_modbus_framer_top;
   import wcmf_pkg::*;

   localparam int CYCLE_LIMIT    = 1_000_000;
   localparam int SETTLE_CYCLES  = 30;
   localparam int RANDOM_PHASES  = 5;
   localparam int FRAMES_PER_PHASE = 70;
   localparam int SPEED_FLOOR    = int'(FLOOR_SPEED);
   localparam int MULTI_FRAME_LEN = 17;
   localparam int SPEED_BYTE0    = 7;      // first byte of the wheel 0 speed
   localparam logic [2:0]  OP_UNUSED_LO    = 3'd5;
   localparam logic [2:0]  OP_UNUSED_HI    = 3'd7;
   localparam logic [15:0] SPEED_REG_BASE  = 16'h0000;
   localparam logic [15:0] SPEED_REG_COUNT = {8'h00, REG_QUANTITY};

   typedef struct packed {
      logic [2:0]         opcode;
      logic [15:0]        reg_address;
      logic [15:0]        reg_value;
      logic signed [15:0] speed_0;
      logic signed [15:0] speed_1;
      logic signed [15:0] speed_2;
      logic signed [15:0] speed_3;
   } motor_cmd_type;

   // Directed row: command plus the mixed right/left speeds where they are obvious
   typedef struct packed {
      motor_cmd_type      cmd;
      logic               mix_known;
      logic signed [15:0] right;
      logic signed [15:0] left;
   } directed_row_type;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       frame_end;
   } frame_beat_type;

   logic               clock;
   logic               reset            = 1'b1;
   logic               csr_write_enable = 1'b0;
   logic               csr_index        = CSR_DEVICE_ADDRESS;
   logic [14:0]        csr_write_data   = '0;
   logic               req_valid        = 1'b0;
   logic               req_stall;
   logic [2:0]         req_opcode       = OP_SINGLE;
   logic [15:0]        req_reg_address  = '0;
   logic [15:0]        req_reg_value    = '0;
   logic signed [15:0] req_speed_0      = '0;
   logic signed [15:0] req_speed_1      = '0;
   logic signed [15:0] req_speed_2      = '0;
   logic signed [15:0] req_speed_3      = '0;
   logic               rsp_valid;
   logic               rsp_stall        = 1'b0;
   logic [7:0]         rsp_frame_byte;
   logic               rsp_frame_end;

   // Local copy of the block's registers
   logic [7:0]  dev_addr_cfg    = DEVICE_ADDRESS_RESET;
   logic [14:0] speed_bound_cfg = SPEED_BOUND_RESET;

   frame_beat_type frame_q [$];
   logic calm = 1'b0;
   int   fail_count     = 0;
   int   cmd_count      = 0;
   int   byte_count     = 0;
   int   settings_count = 1;
   int   cycle_count    = 0;

   directed_row_type directed_rows [0:24] = '{
      '{'{OP_SINGLE, 16'h0000, 16'h0000, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b0, 16'sd0, 16'sd0},
      '{'{OP_SINGLE, 16'hFFFF, 16'hFFFF, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b0, 16'sd0, 16'sd0},
      '{'{OP_RAW, 16'h0000, 16'h0000, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b0, 16'sd0, 16'sd0},
      '{'{OP_RAW, 16'h0000, 16'h0000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000},
        1'b0, 16'sd0, 16'sd0},
      '{'{OP_RAW, 16'h0000, 16'h0000, -16'sd1, -16'sd1, -16'sd1, -16'sd1}, 1'b0, 16'sd0, 16'sd0},
      // negating the most negative fourth wheel wraps back to itself
      '{'{OP_WHEEL, 16'h0000, 16'h0000, 16'sd1, 16'sd2, 16'sd3, 16'sh8000},
        1'b0, 16'sd0, 16'sd0},
      '{'{OP_WHEEL, 16'h0000, 16'h0000, 16'sh8000, 16'sh7FFF, 16'sh5555, 16'sh7FFF},
        1'b0, 16'sd0, 16'sd0},
      '{'{OP_DIFF, 16'h0000, 16'h0000, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, 16'sd0, 16'sd0},
      '{'{OP_DIFF, 16'h0000, 16'h0000, 16'sd10, 16'sd3, 16'sd0, 16'sd0}, 1'b1, 16'sd7, 16'sd13},
      // sums wrap to 16 bits before the clamp
      '{'{OP_DIFF, 16'h0000, 16'h0000, 16'sh7FFF, 16'sh8000, 16'sd0, 16'sd0},
        1'b1, -16'sd1, -16'sd1},
      '{'{OP_DIFF, 16'h0000, 16'h0000, 16'sh8000, 16'sh7FFF, 16'sd0, 16'sd0},
        1'b1, 16'sd1, -16'sd1},
      '{'{OP_DIFF, 16'h0000, 16'h0000, 16'sd100, 16'sd0, 16'sd0, 16'sd0},
        1'b1, 16'sd20, 16'sd20},
      '{'{OP_DIFF, 16'h0000, 16'h0000, -16'sd100, 16'sd0, 16'sd0, 16'sd0},
        1'b1, -16'sd20, -16'sd20},
      '{'{OP_LINE, 16'h0000, 16'h0000, 16'sd10, 16'sd0, 16'sd0, 16'sd0}, 1'b1, 16'sd10, 16'sd10},
      '{'{OP_LINE, 16'h0000, 16'h0000, 16'sd10, 16'sd4, 16'sd0, 16'sd0}, 1'b1, 16'sd6, 16'sd12},
      '{'{OP_LINE, 16'h0000, 16'h0000, 16'sd10, -16'sd5, 16'sd0, 16'sd0},
        1'b1, 16'sd12, 16'sd5},
      // odd steer: halving truncates toward zero
      '{'{OP_LINE, 16'h0000, 16'h0000, 16'sd10, 16'sd3, 16'sd0, 16'sd0}, 1'b1, 16'sd7, 16'sd11},
      '{'{OP_LINE, 16'h0000, 16'h0000, 16'sd10, -16'sd3, 16'sd0, 16'sd0},
        1'b1, 16'sd11, 16'sd7},
      '{'{OP_LINE, 16'h0000, 16'h0000, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, 16'sd4, 16'sd4},
      '{'{OP_LINE, 16'h0000, 16'h0000, 16'sh7FFF, 16'sd1, 16'sd0, 16'sd0},
        1'b1, 16'sd20, 16'sd20},
      '{'{OP_LINE, 16'h0000, 16'h0000, 16'sh7FFF, 16'sh7FFF, 16'sd0, 16'sd0},
        1'b1, 16'sd4, 16'sd4},
      '{'{OP_LINE, 16'h0000, 16'h0000, 16'sh8000, 16'sh8000, 16'sd0, 16'sd0},
        1'b1, 16'sd4, 16'sd4},
      '{'{OP_LINE, 16'h0000, 16'h0000, 16'sd5, -16'sd7, 16'sd0, 16'sd0}, 1'b1, 16'sd8, 16'sd4},
      // unused opcodes are taken and produce no frame
      '{'{OP_UNUSED_LO, 16'hFFFF, 16'hFFFF, -16'sd1, -16'sd1, -16'sd1, -16'sd1},
        1'b0, 16'sd0, 16'sd0},
      '{'{OP_UNUSED_HI, 16'hFFFF, 16'hFFFF, -16'sd1, -16'sd1, -16'sd1, -16'sd1},
        1'b0, 16'sd0, 16'sd0}
   };

   wheel_command_modbus_framer_top u_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_opcode       (req_opcode),
      .req_reg_address  (req_reg_address),
      .req_reg_value    (req_reg_value),
      .req_speed_0      (req_speed_0),
      .req_speed_1      (req_speed_1),
      .req_speed_2      (req_speed_2),
      .req_speed_3      (req_speed_3),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_frame_byte   (rsp_frame_byte),
      .rsp_frame_end    (rsp_frame_end)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Keep 16 bits and reinterpret as signed
   function automatic int wrap16(input int v);
      logic signed [15:0] t;
      t = v[15:0];
      return int'(t);
   endfunction

   function automatic int clip_speed(input int v);
      int lim;
      lim = int'(speed_bound_cfg);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
   endfunction

   // Modbus CRC-16 over the frame so far
   function automatic logic [15:0] modbus_crc(input logic [7:0] f [$]);
      logic [15:0] crc;
      crc = CRC_INIT;
      foreach (f[i]) begin
         crc = crc ^ {8'h00, f[i]};
         repeat (8) crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
      end
      return crc;
   endfunction

   // Build the full frame a command should produce under the current registers
   function automatic void build_frame(input motor_cmd_type c, output logic [7:0] f [$]);
      int                 s0;
      int                 s1;
      int                 right;
      int                 left;
      logic signed [15:0] w [4];
      logic [15:0]        crc;
      f = {};
      if (c.opcode > OP_LINE) return;
      s0 = $signed(c.speed_0);
      s1 = $signed(c.speed_1);
      f.push_back(dev_addr_cfg);
      if (c.opcode == OP_SINGLE) begin
         f.push_back(FUNC_WRITE_SINGLE);
         f.push_back(c.reg_address[15:8]);
         f.push_back(c.reg_address[7:0]);
         f.push_back(c.reg_value[15:8]);
         f.push_back(c.reg_value[7:0]);
      end else begin
         if (c.opcode == OP_RAW || c.opcode == OP_WHEEL) begin
            w[0] = c.speed_0;
            w[1] = c.speed_1;
            w[2] = c.speed_2;
            w[3] = c.speed_3;
         end else begin
            if (c.opcode == OP_DIFF) begin
               right = clip_speed(wrap16(s0 - s1));
               left  = clip_speed(wrap16(s0 + s1));
            end else begin
               right = s0;
               left  = s0;
               if (s1 > 0) begin
                  right = wrap16(s0 - s1);
                  left  = wrap16(s0 + s1 / 2);
               end else if (s1 < 0) begin
                  right = wrap16(s0 + (-s1) / 2);
                  left  = wrap16(s0 + s1);
               end
               if (right < SPEED_FLOOR) right = SPEED_FLOOR;
               if (left < SPEED_FLOOR) left = SPEED_FLOOR;
               right = clip_speed(right);
               left  = clip_speed(left);
            end
            w[0] = right[15:0];
            w[1] = right[15:0];
            w[2] = left[15:0];
            w[3] = left[15:0];
         end
         // fourth wheel runs mirrored
         if (c.opcode != OP_RAW) w[3] = -w[3];
         f.push_back(FUNC_WRITE_MULTI);
         f.push_back(SPEED_REG_BASE[15:8]);
         f.push_back(SPEED_REG_BASE[7:0]);
         f.push_back(SPEED_REG_COUNT[15:8]);
         f.push_back(SPEED_REG_COUNT[7:0]);
         f.push_back(BYTE_COUNT);
         for (int i = 0; i < 4; i++) begin
            f.push_back(w[i][15:8]);
            f.push_back(w[i][7:0]);
         end
      end
      crc = modbus_crc(f);
      f.push_back(crc[7:0]);
      f.push_back(crc[15:8]);
   endfunction

   task automatic queue_frame(input logic [7:0] f [$]);
      foreach (f[i]) frame_q.push_back('{f[i], i == f.size() - 1});
   endtask

   function automatic logic signed [15:0] random_speed();
      int near;
      case ($urandom_range(0, 4))
         0: return 16'($urandom_range(0, 128) - 64);
         1: begin
            case ($urandom_range(0, 3))
               0: return 16'sh7FFF;
               1: return 16'sh8000;
               2: return 16'sd0;
               default: return -16'sd1;
            endcase
         end
         2: begin
            // around the clamp bound, either sign
            near = int'(speed_bound_cfg) + $urandom_range(0, 6) - 3;
            return 16'($urandom_range(0, 1) ? near : -near);
         end
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic motor_cmd_type random_cmd();
      motor_cmd_type c;
      if ($urandom_range(0, 9) == 0) c.opcode = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
      else c.opcode = 3'($urandom_range(OP_SINGLE, OP_LINE));
      c.reg_address = 16'($urandom);
      c.reg_value   = 16'($urandom);
      c.speed_0     = random_speed();
      c.speed_1     = random_speed();
      c.speed_2     = random_speed();
      c.speed_3     = random_speed();
      return c;
   endfunction

   // Drive one command and hold it until the block takes the transfer
   task automatic transfer_cmd(input motor_cmd_type c);
      int gap;
      gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 19) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_opcode      <= c.opcode;
      req_reg_address <= c.reg_address;
      req_reg_value   <= c.reg_value;
      req_speed_0     <= c.speed_0;
      req_speed_1     <= c.speed_1;
      req_speed_2     <= c.speed_2;
      req_speed_3     <= c.speed_3;
      do @(posedge clock); while (req_stall);
      cmd_count++;
   endtask

   // Hold off commands until every frame byte is out and the sequencer is idle
   task automatic settle();
      req_valid <= 1'b0;
      while (frame_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic apply_settings(input logic [7:0] addr, input logic [14:0] limit);
      settle();
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_DEVICE_ADDRESS;
      csr_write_data   <= 15'(addr);
      @(posedge clock);
      csr_index        <= CSR_SPEED_BOUND;
      csr_write_data   <= limit;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      dev_addr_cfg    = addr;
      speed_bound_cfg = limit;
      settings_count++;
   endtask

   // Receiver stalls in random bursts, none once the run turns calm
   initial begin
      forever begin
         repeat ($urandom_range(1, 30)) @(posedge clock);
         if (!calm && $urandom_range(0, 1) == 1) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 19)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Compare every accepted frame byte with the oldest expectation
   always @(posedge clock) begin : frame_check
      frame_beat_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (frame_q.size() == 0) begin
            $error("frame_byte: none expected, got 0x%02h", rsp_frame_byte);
            fail_count++;
         end else begin
            want = frame_q.pop_front();
            byte_count++;
            if (rsp_frame_byte !== want.frame_byte) begin
               $error("frame_byte: expected 0x%02h, got 0x%02h",
                      want.frame_byte, rsp_frame_byte);
               fail_count++;
            end
            if (rsp_frame_end !== want.frame_end) begin
               $error("frame_end: expected %0b, got %0b", want.frame_end, rsp_frame_end);
               fail_count++;
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("wheel_command_modbus_framer_top: mismatch");
         $finish;
      end
   end

   initial begin : stimulus
      motor_cmd_type c;
      logic [7:0]  f [$];
      int          framed;
      logic [7:0]  addr;
      logic [14:0] limit;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed commands under the reset register values
      foreach (directed_rows[r]) begin
         c = directed_rows[r].cmd;
         transfer_cmd(c);
         build_frame(c, f);
         if (directed_rows[r].mix_known && f.size() == MULTI_FRAME_LEN) begin
            f[SPEED_BYTE0]     = directed_rows[r].right[15:8];
            f[SPEED_BYTE0 + 1] = directed_rows[r].right[7:0];
            f[SPEED_BYTE0 + 2] = directed_rows[r].right[15:8];
            f[SPEED_BYTE0 + 3] = directed_rows[r].right[7:0];
            f[SPEED_BYTE0 + 4] = directed_rows[r].left[15:8];
            f[SPEED_BYTE0 + 5] = directed_rows[r].left[7:0];
         end
         queue_frame(f);
      end

      // Random commands, one register setting per phase
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: begin addr = 8'h00; limit = 15'd4; end
            1: begin addr = 8'hFF; limit = 15'h7FFF; end
            2: begin addr = 8'($urandom); limit = 15'($urandom_range(0, 3)); end
            3: begin addr = 8'($urandom); limit = 15'($urandom_range(4, 32767)); end
            default: begin addr = 8'($urandom); limit = 15'($urandom_range(4, 400)); end
         endcase
         apply_settings(addr, limit);
         framed = 0;
         while (framed < FRAMES_PER_PHASE) begin
            if (p == 2 && framed == FRAMES_PER_PHASE / 2) settle();
            if (p == RANDOM_PHASES - 1 && framed >= FRAMES_PER_PHASE / 2) calm = 1'b1;
            c = random_cmd();
            transfer_cmd(c);
            build_frame(c, f);
            queue_frame(f);
            if (c.opcode <= OP_LINE) framed++;
         end
      end

      // Drain
      req_valid <= 1'b0;
      while (frame_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d commands across %0d register settings, checked %0d frame bytes.",
               cmd_count, settings_count, byte_count);
      if (fail_count == 0) begin
         $display("wheel_command_modbus_framer_top: match");
      end else begin
         $display("wheel_command_modbus_framer_top: mismatch");
      end
      $finish;
   end

endmodule
